[rtl/point_in_triangle_test_macros.svh]
// ============================================================================
// point_in_triangle_test_macros.svh
// assertion macros shared by the point-in-triangle test rtl
// ============================================================================
`ifndef POINT_IN_TRIANGLE_TEST_MACROS_SVH
`define POINT_IN_TRIANGLE_TEST_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define PIT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on every rising edge outside reset
`define PIT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/pit_pkg.sv]
// ============================================================================
// pit_pkg
// shared constants and types of the point-in-triangle test
// ============================================================================
package pit_pkg;

    // default coordinate width
    localparam int COORD_BITS_DEF = 16;

    // width of a dot product of two corner differences
    localparam int DOT_BITS_DEF = 2 * COORD_BITS_DEF + 4;

    // load enables of the two stages inside a split multiplier
    typedef struct packed {
        logic pp_en;
        logic sum_en;
    } pit_en_t;

endpackage

[rtl/pit_wide_mul.sv]
// ============================================================================
// pit_wide_mul
// two-stage signed multiplier: four half-width partial products, then a sum
// ============================================================================
module pit_wide_mul #(
    parameter int N = pit_pkg::DOT_BITS_DEF
) (
    input  logic                    clk,
    input  pit_pkg::pit_en_t        en,
    input  logic signed [N-1:0]     x,
    input  logic signed [N-1:0]     y,
    output logic signed [2*N-1:0]   prod
);
    import pit_pkg::*;

    localparam int L  = (N + 1) / 2;
    localparam int H  = N - L;
    localparam int PW = 2 * N;

    // operand halves: signed upper part, unsigned lower part
    logic signed [H-1:0]     xh;
    logic signed [H-1:0]     yh;
    logic signed [L:0]       xl_s;
    logic signed [L:0]       yl_s;
    logic [L-1:0]            xl;
    logic [L-1:0]            yl;

    logic signed [2*H-1:0]   hh_next;
    logic signed [H+L:0]     hl_next;
    logic signed [H+L:0]     lh_next;
    logic [2*L-1:0]          ll_next;

    logic signed [2*H-1:0]   hh_reg;
    logic signed [H+L:0]     hl_reg;
    logic signed [H+L:0]     lh_reg;
    logic [2*L-1:0]          ll_reg;

    logic signed [PW-1:0]    hh_ext;
    logic signed [PW-1:0]    hl_ext;
    logic signed [PW-1:0]    lh_ext;
    logic [PW-1:0]           ll_ext;
    logic signed [PW-1:0]    prod_next;
    logic signed [PW-1:0]    prod_reg;

    // partial products
    always_comb
    begin
        xh      = x[N-1:L];
        yh      = y[N-1:L];
        xl      = x[L-1:0];
        yl      = y[L-1:0];
        xl_s    = $signed({1'b0, xl});
        yl_s    = $signed({1'b0, yl});
        hh_next = xh * yh;
        hl_next = xh * yl_s;
        lh_next = xl_s * yh;
        ll_next = xl * yl;
    end

    always_ff @(posedge clk)
    begin
        if (en.pp_en)
        begin
            hh_reg <= hh_next;
            hl_reg <= hl_next;
            lh_reg <= lh_next;
            ll_reg <= ll_next;
        end
    end

    // shifted sum of the partial products
    always_comb
    begin
        hh_ext    = PW'(hh_reg);
        hl_ext    = PW'(hl_reg);
        lh_ext    = PW'(lh_reg);
        ll_ext    = PW'(ll_reg);
        prod_next = (hh_ext <<< (2 * L)) + ((hl_ext + lh_ext) <<< L) + $signed(ll_ext);
    end

    always_ff @(posedge clk)
    begin
        if (en.sum_en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

[rtl/point_in_triangle_test.sv]
// ============================================================================
// point_in_triangle_test
// Decides whether point P lies inside triangle ABC by exact integer
// barycentric sign tests. Edges AB and AC count as inside, edge BC does not;
// a zero-area triangle reports degenerate with inside_res low.
// Input channel: in_valid / in_ready carry one word of twelve signed
// coordinates (P, A, B, C). Output channel: out_valid / out_ready carry
// inside_res and degenerate, one result word per input word, in order.
// Pipeline: seven register stages. Throughput: one word per cycle while the
// receiver holds out_ready high, set by the pipeline of differences, products,
// dot sums, split 4-way multipliers and sign tests. Each stage moves forward
// whenever the stage after it is free, so empty stages fill up while the
// receiver stalls; in_ready falls only once all seven stages hold a word.
// Reset clears every valid bit; the pipeline is empty and in_ready is high
// right after reset.
// ============================================================================
`include "point_in_triangle_test_macros.svh"

module point_in_triangle_test #(
    parameter int COORD_BITS = pit_pkg::COORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [COORD_BITS-1:0] pt_x,
    input  logic signed [COORD_BITS-1:0] pt_y,
    input  logic signed [COORD_BITS-1:0] pt_z,
    input  logic signed [COORD_BITS-1:0] a_x,
    input  logic signed [COORD_BITS-1:0] a_y,
    input  logic signed [COORD_BITS-1:0] a_z,
    input  logic signed [COORD_BITS-1:0] b_x,
    input  logic signed [COORD_BITS-1:0] b_y,
    input  logic signed [COORD_BITS-1:0] b_z,
    input  logic signed [COORD_BITS-1:0] c_x,
    input  logic signed [COORD_BITS-1:0] c_y,
    input  logic signed [COORD_BITS-1:0] c_z,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         inside_res,
    output logic                         degenerate
);
    import pit_pkg::*;

    localparam int NUM_STAGES = 7;
    localparam int DW   = COORD_BITS + 1;       // corner difference
    localparam int PPW  = 2 * COORD_BITS + 2;   // product of differences
    localparam int DOTW = 2 * COORD_BITS + 4;   // dot product
    localparam int BW   = 2 * DOTW;             // product of dot products
    localparam int NW   = BW + 2;               // d, nu, nv
    localparam int SW   = NW + 2;               // nu + nv - d

    // pipeline control
    logic [NUM_STAGES-1:0] v_reg;
    logic [NUM_STAGES-1:0] adv;
    pit_en_t               mul_en;

    // stage 0: corner differences
    logic signed [COORD_BITS-1:0] p_c [3];
    logic signed [COORD_BITS-1:0] a_c [3];
    logic signed [COORD_BITS-1:0] b_c [3];
    logic signed [COORD_BITS-1:0] c_c [3];
    logic signed [DW-1:0]  ab_next [3];
    logic signed [DW-1:0]  ac_next [3];
    logic signed [DW-1:0]  ap_next [3];
    logic signed [DW-1:0]  ab_reg [3];
    logic signed [DW-1:0]  ac_reg [3];
    logic signed [DW-1:0]  ap_reg [3];

    // stage 1: per-axis products
    logic signed [PPW-1:0] abab_next [3];
    logic signed [PPW-1:0] abac_next [3];
    logic signed [PPW-1:0] abap_next [3];
    logic signed [PPW-1:0] acac_next [3];
    logic signed [PPW-1:0] acap_next [3];
    logic signed [PPW-1:0] abab_reg [3];
    logic signed [PPW-1:0] abac_reg [3];
    logic signed [PPW-1:0] abap_reg [3];
    logic signed [PPW-1:0] acac_reg [3];
    logic signed [PPW-1:0] acap_reg [3];

    // stage 2: dot products
    logic signed [DOTW-1:0] abb_next;
    logic signed [DOTW-1:0] abc_next;
    logic signed [DOTW-1:0] abp_next;
    logic signed [DOTW-1:0] acc_next;
    logic signed [DOTW-1:0] acp_next;
    logic signed [DOTW-1:0] abb_reg;
    logic signed [DOTW-1:0] abc_reg;
    logic signed [DOTW-1:0] abp_reg;
    logic signed [DOTW-1:0] acc_reg;
    logic signed [DOTW-1:0] acp_reg;

    // stages 3 and 4: products of dot products
    logic signed [BW-1:0] p_abb_acc;
    logic signed [BW-1:0] p_abc_abc;
    logic signed [BW-1:0] p_acc_abp;
    logic signed [BW-1:0] p_abc_acp;
    logic signed [BW-1:0] p_abb_acp;
    logic signed [BW-1:0] p_abc_abp;

    // stage 5: determinant and numerators
    logic signed [NW-1:0] d_next;
    logic signed [NW-1:0] nu_next;
    logic signed [NW-1:0] nv_next;
    logic signed [NW-1:0] d_reg;
    logic signed [NW-1:0] nu_reg;
    logic signed [NW-1:0] nv_reg;

    // stage 6: result flags
    logic signed [SW-1:0] lim_next;
    logic                 deg_next;
    logic                 inside_next;
    logic                 deg_reg;
    logic                 inside_reg;

    // stage advance: a stage loads when it is empty or the next one moves
    always_comb
    begin
        adv[NUM_STAGES-1] = !v_reg[NUM_STAGES-1] || out_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            adv[k] = !v_reg[k] || adv[k+1];
        end
        mul_en.pp_en  = adv[3];
        mul_en.sum_en = adv[4];
    end

    assign in_ready = adv[0];

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++)
            begin
                if (adv[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // corner differences AB, AC, AP
    always_comb
    begin
        p_c[0] = pt_x;
        p_c[1] = pt_y;
        p_c[2] = pt_z;
        a_c[0] = a_x;
        a_c[1] = a_y;
        a_c[2] = a_z;
        b_c[0] = b_x;
        b_c[1] = b_y;
        b_c[2] = b_z;
        c_c[0] = c_x;
        c_c[1] = c_y;
        c_c[2] = c_z;
        for (int k = 0; k < 3; k++)
        begin
            ab_next[k] = DW'(b_c[k]) - DW'(a_c[k]);
            ac_next[k] = DW'(c_c[k]) - DW'(a_c[k]);
            ap_next[k] = DW'(p_c[k]) - DW'(a_c[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            ab_reg <= ab_next;
            ac_reg <= ac_next;
            ap_reg <= ap_next;
        end
    end

    // per-axis products
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            abab_next[k] = ab_reg[k] * ab_reg[k];
            abac_next[k] = ab_reg[k] * ac_reg[k];
            abap_next[k] = ab_reg[k] * ap_reg[k];
            acac_next[k] = ac_reg[k] * ac_reg[k];
            acap_next[k] = ac_reg[k] * ap_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            abab_reg <= abab_next;
            abac_reg <= abac_next;
            abap_reg <= abap_next;
            acac_reg <= acac_next;
            acap_reg <= acap_next;
        end
    end

    // dot products
    always_comb
    begin
        abb_next = DOTW'(abab_reg[0]) + DOTW'(abab_reg[1]) + DOTW'(abab_reg[2]);
        abc_next = DOTW'(abac_reg[0]) + DOTW'(abac_reg[1]) + DOTW'(abac_reg[2]);
        abp_next = DOTW'(abap_reg[0]) + DOTW'(abap_reg[1]) + DOTW'(abap_reg[2]);
        acc_next = DOTW'(acac_reg[0]) + DOTW'(acac_reg[1]) + DOTW'(acac_reg[2]);
        acp_next = DOTW'(acap_reg[0]) + DOTW'(acap_reg[1]) + DOTW'(acap_reg[2]);
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            abb_reg <= abb_next;
            abc_reg <= abc_next;
            abp_reg <= abp_next;
            acc_reg <= acc_next;
            acp_reg <= acp_next;
        end
    end

    // products of dot products, two stages each
    pit_wide_mul #(.N(DOTW)) u_mul_abb_acc (
        .clk  (clk),
        .en   (mul_en),
        .x    (abb_reg),
        .y    (acc_reg),
        .prod (p_abb_acc)
    );

    pit_wide_mul #(.N(DOTW)) u_mul_abc_abc (
        .clk  (clk),
        .en   (mul_en),
        .x    (abc_reg),
        .y    (abc_reg),
        .prod (p_abc_abc)
    );

    pit_wide_mul #(.N(DOTW)) u_mul_acc_abp (
        .clk  (clk),
        .en   (mul_en),
        .x    (acc_reg),
        .y    (abp_reg),
        .prod (p_acc_abp)
    );

    pit_wide_mul #(.N(DOTW)) u_mul_abc_acp (
        .clk  (clk),
        .en   (mul_en),
        .x    (abc_reg),
        .y    (acp_reg),
        .prod (p_abc_acp)
    );

    pit_wide_mul #(.N(DOTW)) u_mul_abb_acp (
        .clk  (clk),
        .en   (mul_en),
        .x    (abb_reg),
        .y    (acp_reg),
        .prod (p_abb_acp)
    );

    pit_wide_mul #(.N(DOTW)) u_mul_abc_abp (
        .clk  (clk),
        .en   (mul_en),
        .x    (abc_reg),
        .y    (abp_reg),
        .prod (p_abc_abp)
    );

    // determinant and barycentric numerators
    always_comb
    begin
        d_next  = NW'(p_abb_acc) - NW'(p_abc_abc);
        nu_next = NW'(p_acc_abp) - NW'(p_abc_acp);
        nv_next = NW'(p_abb_acp) - NW'(p_abc_abp);
    end

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            d_reg  <= d_next;
            nu_reg <= nu_next;
            nv_reg <= nv_next;
        end
    end

    // sign tests: nu >= 0, nv >= 0, nu + nv < d, d nonzero
    always_comb
    begin
        lim_next    = SW'(nu_reg) + SW'(nv_reg) - SW'(d_reg);
        deg_next    = (d_reg == '0);
        inside_next = !deg_next && !nu_reg[NW-1] && !nv_reg[NW-1] && lim_next[SW-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            deg_reg    <= deg_next;
            inside_reg <= inside_next;
        end
    end

    assign out_valid  = v_reg[NUM_STAGES-1];
    assign inside_res = inside_reg;
    assign degenerate = deg_reg;

    // checks
    `PIT_ASSERT_NOW(a_deg_not_inside, out_valid && degenerate, !inside_res, "degenerate word flagged inside")
    `PIT_ASSERT_NOW(a_full_when_blocked, !in_ready, &v_reg, "input blocked with an empty stage")
    `PIT_ASSERT_NEXT(a_last_handoff, v_reg[NUM_STAGES-2] && adv[NUM_STAGES-1], v_reg[NUM_STAGES-1], "word lost at output stage")

endmodule

[tb/pit_checker.sv]
`timescale 1ns / 100ps
// ============================================================================
// pit_checker
// Watches both channels of the point-in-triangle test. Every accepted input
// word is classified here with exact wide integer arithmetic, and each
// accepted result word is compared in order against the oldest prediction.
// ============================================================================
module pit_checker #(
    parameter int COORD_BITS = pit_pkg::COORD_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic [COORD_BITS-1:0] pt_x,
    input  logic [COORD_BITS-1:0] pt_y,
    input  logic [COORD_BITS-1:0] pt_z,
    input  logic [COORD_BITS-1:0] a_x,
    input  logic [COORD_BITS-1:0] a_y,
    input  logic [COORD_BITS-1:0] a_z,
    input  logic [COORD_BITS-1:0] b_x,
    input  logic [COORD_BITS-1:0] b_y,
    input  logic [COORD_BITS-1:0] b_z,
    input  logic [COORD_BITS-1:0] c_x,
    input  logic [COORD_BITS-1:0] c_y,
    input  logic [COORD_BITS-1:0] c_z,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic                  inside_res,
    input  logic                  degenerate,
    output int                    fail_count,
    output int                    pending
);

    typedef logic signed [COORD_BITS-1:0] coord_t;

    // wide enough that no product or difference can overflow
    typedef logic signed [159:0] wide_t;

    typedef struct packed {
        logic in_tri;
        logic degenerate;
    } verdict_t;

    verdict_t verdict_q[$];
    verdict_t want;
    int       errs = 0;

    assign fail_count = errs;

    // barycentric sign tests on the projection of p onto the triangle plane
    function automatic verdict_t classify_point(input coord_t p [3], input coord_t a [3],
                                                input coord_t b [3], input coord_t c [3]);
        wide_t    ab [3];
        wide_t    ac [3];
        wide_t    ap [3];
        wide_t    abb, abc, abp, acc, acp;
        wide_t    area2, nu, nv;
        verdict_t v;
        for (int k = 0; k < 3; k++)
        begin
            ab[k] = wide_t'(b[k]) - wide_t'(a[k]);
            ac[k] = wide_t'(c[k]) - wide_t'(a[k]);
            ap[k] = wide_t'(p[k]) - wide_t'(a[k]);
        end
        abb = ab[0] * ab[0] + ab[1] * ab[1] + ab[2] * ab[2];
        abc = ab[0] * ac[0] + ab[1] * ac[1] + ab[2] * ac[2];
        abp = ab[0] * ap[0] + ab[1] * ap[1] + ab[2] * ap[2];
        acc = ac[0] * ac[0] + ac[1] * ac[1] + ac[2] * ac[2];
        acp = ac[0] * ap[0] + ac[1] * ap[1] + ac[2] * ap[2];
        area2 = abb * acc - abc * abc;
        nu    = acc * abp - abc * acp;
        nv    = abb * acp - abc * abp;
        // zero-area triangle forces inside low
        v.degenerate = (area2 == 0);
        v.in_tri     = !v.degenerate && (nu >= 0) && (nv >= 0) && (nu + nv < area2);
        return v;
    endfunction

    // result side first so a same-edge input word cannot pair with it
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (verdict_q.size() == 0)
                begin
                    $error("result word with no prediction waiting");
                    errs++;
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (inside_res !== want.in_tri)
                    begin
                        $error("inside_res mismatch: expected %0b, actual %0b",
                               want.in_tri, inside_res);
                        errs++;
                    end
                    if (degenerate !== want.degenerate)
                    begin
                        $error("degenerate mismatch: expected %0b, actual %0b",
                               want.degenerate, degenerate);
                        errs++;
                    end
                end
            end
            if (in_valid && in_ready)
                verdict_q.push_back(classify_point('{pt_x, pt_y, pt_z}, '{a_x, a_y, a_z},
                                                   '{b_x, b_y, b_z}, '{c_x, c_y, c_z}));
            pending <= verdict_q.size();
        end
    end

endmodule

[tb/tb_point_in_triangle_test.sv]
`timescale 1ns / 100ps
// ============================================================================
// tb_point_in_triangle_test
// Drives point and triangle words into the point-in-triangle test: directed
// corner cases first, then a random mix of lattice-built triangles with
// points on and near the edges, degenerate triangles and full-range noise.
// Sender bursts and receiver stalls are random; a checker scores the results.
// ============================================================================
module tb_point_in_triangle_test;

    localparam int COORD_BITS     = pit_pkg::COORD_BITS_DEF;
    localparam int LO             = -32768;
    localparam int HI             = 32767;
    localparam int RANDOM_WORDS   = 1630;
    localparam int HOLD_CYCLES    = 64;
    localparam int TAIL_CYCLES    = 16;
    localparam int WATCHDOG_LIMIT = 3000;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct {
        coord_t p [3];
        coord_t a [3];
        coord_t b [3];
        coord_t c [3];
    } tri_word_t;

    typedef enum int {GEN_UNIFORM, GEN_LATTICE, GEN_DEGENERATE, GEN_TINY, GEN_EXTREME} gen_kind_t;

    logic   clk;
    logic   rst_n;
    logic   in_valid;
    logic   in_ready;
    coord_t pt_x, pt_y, pt_z;
    coord_t a_x, a_y, a_z;
    coord_t b_x, b_y, b_z;
    coord_t c_x, c_y, c_z;
    logic   out_valid;
    logic   out_ready;
    logic   inside_res;
    logic   degenerate;
    int     fail_count;
    int     pending;

    // sender burst state and pressure handshake with the receiver
    int     burst_left  = 4;
    int     steady_left = 0;
    logic   hold_off_req = 1'b0;
    logic   hold_active  = 1'b0;

    point_in_triangle_test #(
        .COORD_BITS(COORD_BITS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .pt_x       (pt_x),
        .pt_y       (pt_y),
        .pt_z       (pt_z),
        .a_x        (a_x),
        .a_y        (a_y),
        .a_z        (a_z),
        .b_x        (b_x),
        .b_y        (b_y),
        .b_z        (b_z),
        .c_x        (c_x),
        .c_y        (c_y),
        .c_z        (c_z),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .inside_res (inside_res),
        .degenerate (degenerate)
    );

    pit_checker #(
        .COORD_BITS(COORD_BITS)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .pt_x       (pt_x),
        .pt_y       (pt_y),
        .pt_z       (pt_z),
        .a_x        (a_x),
        .a_y        (a_y),
        .a_z        (a_z),
        .b_x        (b_x),
        .b_y        (b_y),
        .b_z        (b_z),
        .c_x        (c_x),
        .c_y        (c_y),
        .c_z        (c_z),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .inside_res (inside_res),
        .degenerate (degenerate),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic tri_word_t make_word(input int px, py, pz, ax, ay, az,
                                            input int bx, by, bz, cx, cy, cz);
        tri_word_t w;
        w.p = '{coord_t'(px), coord_t'(py), coord_t'(pz)};
        w.a = '{coord_t'(ax), coord_t'(ay), coord_t'(az)};
        w.b = '{coord_t'(bx), coord_t'(by), coord_t'(bz)};
        w.c = '{coord_t'(cx), coord_t'(cy), coord_t'(cz)};
        return w;
    endfunction

    // uniform in -r..r
    function automatic int srand(input int r);
        return int'($urandom_range(0, 2 * r)) - r;
    endfunction

    function automatic int extreme_value();
        case ($urandom_range(0, 6))
            0:       return LO;
            1:       return LO + 1;
            2:       return -1;
            3:       return 0;
            4:       return 1;
            5:       return HI - 1;
            default: return HI;
        endcase
    endfunction

    function automatic tri_word_t random_word();
        tri_word_t w;
        gen_kind_t kind;
        int        roll, n, r, s, t, k1, k2, jitter;
        int        a [3];
        int        e1 [3];
        int        e2 [3];
        roll = $urandom_range(0, 99);
        kind = (roll < 25) ? GEN_UNIFORM :
               (roll < 70) ? GEN_LATTICE :
               (roll < 82) ? GEN_DEGENERATE :
               (roll < 90) ? GEN_TINY : GEN_EXTREME;
        case (kind)
            GEN_LATTICE:
            begin
                // b = a + n*e1, c = a + n*e2, p on the lattice so edges are hit exactly, or jittered off it
                n = $urandom_range(1, 40);
                r = 6000 / (n + 2);
                case ($urandom_range(0, 5))
                    0:
                    begin
                        s = 0;
                        t = $urandom_range(0, n);
                    end
                    1:
                    begin
                        t = 0;
                        s = $urandom_range(0, n);
                    end
                    2:
                    begin
                        s = $urandom_range(0, n);
                        t = n - s;
                    end
                    default:
                    begin
                        s = int'($urandom_range(0, n + 4)) - 2;
                        t = int'($urandom_range(0, n + 4)) - 2;
                    end
                endcase
                jitter = $urandom_range(0, 2);
                for (int k = 0; k < 3; k++)
                begin
                    a[k]  = srand(8000);
                    e1[k] = srand(r);
                    e2[k] = srand(r);
                    w.a[k] = coord_t'(a[k]);
                    w.b[k] = coord_t'(a[k] + n * e1[k]);
                    w.c[k] = coord_t'(a[k] + n * e2[k]);
                    w.p[k] = coord_t'(a[k] + s * e1[k] + t * e2[k] +
                                      ((jitter == 1) ? srand(2) :
                                       (jitter == 2) ? srand(1500) : 0));
                end
            end
            GEN_DEGENERATE:
            begin
                k1 = int'($urandom_range(0, 6)) - 3;
                k2 = int'($urandom_range(0, 6)) - 3;
                roll = $urandom_range(0, 2);
                for (int k = 0; k < 3; k++)
                begin
                    a[k]  = srand(20000);
                    e1[k] = srand(3000);
                    w.p[k] = coord_t'($urandom);
                    w.a[k] = coord_t'(a[k]);
                    w.b[k] = coord_t'((roll == 0) ? a[k] : a[k] + k1 * e1[k]);
                    w.c[k] = coord_t'((roll == 0) ? a[k] : a[k] + k2 * e1[k]);
                end
            end
            GEN_TINY:
                for (int k = 0; k < 3; k++)
                begin
                    w.p[k] = coord_t'(srand(4));
                    w.a[k] = coord_t'(srand(4));
                    w.b[k] = coord_t'(srand(4));
                    w.c[k] = coord_t'(srand(4));
                end
            GEN_EXTREME:
                for (int k = 0; k < 3; k++)
                begin
                    w.p[k] = coord_t'(extreme_value());
                    w.a[k] = coord_t'(extreme_value());
                    w.b[k] = coord_t'(extreme_value());
                    w.c[k] = coord_t'(extreme_value());
                end
            default:
                for (int k = 0; k < 3; k++)
                begin
                    w.p[k] = coord_t'($urandom);
                    w.a[k] = coord_t'($urandom);
                    w.b[k] = coord_t'($urandom);
                    w.c[k] = coord_t'($urandom);
                end
        endcase
        return w;
    endfunction

    // present one word and hold it until accepted, then maybe idle a while
    task automatic offer_word(input tri_word_t w);
        int gap;
        {pt_x, pt_y, pt_z} <= {w.p[0], w.p[1], w.p[2]};
        {a_x, a_y, a_z}    <= {w.a[0], w.a[1], w.a[2]};
        {b_x, b_y, b_z}    <= {w.b[0], w.b[1], w.b[2]};
        {c_x, c_y, c_z}    <= {w.c[0], w.c[1], w.c[2]};
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (steady_left > 0)
            steady_left--;
        else
        begin
            burst_left--;
            if (burst_left <= 0)
            begin
                gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 4);
                burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                          : $urandom_range(1, 12);
                in_valid <= 1'b0;
                repeat (gap)
                    @(posedge clk);
            end
        end
    endtask

    // stop offering until every outstanding result word has come back
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // stimulus
    initial
    begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        {pt_x, pt_y, pt_z, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z} = '0;
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero-area: all corners coincide
        offer_word(make_word(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        offer_word(make_word(HI, HI, HI, HI, HI, HI, HI, HI, HI, HI, HI, HI));
        offer_word(make_word(LO, LO, LO, LO, LO, LO, LO, LO, LO, LO, LO, LO));
        // full-span triangle: vertex a inside, vertices b and c on the excluded edge
        offer_word(make_word(LO, LO, LO, LO, LO, LO, HI, LO, LO, LO, HI, LO));
        offer_word(make_word(HI, LO, LO, LO, LO, LO, HI, LO, LO, LO, HI, LO));
        offer_word(make_word(LO, HI, LO, LO, LO, LO, HI, LO, LO, LO, HI, LO));
        // far off-plane points projecting just past and just short of edge bc
        offer_word(make_word(0, 0, HI, LO, LO, LO, HI, LO, LO, LO, HI, LO));
        offer_word(make_word(-1, -1, HI, LO, LO, LO, HI, LO, LO, LO, HI, LO));
        // small triangle: on ab, on ac, on bc, interior, off-plane, outside
        offer_word(make_word(128, 0, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0));
        offer_word(make_word(0, 128, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0));
        offer_word(make_word(128, 128, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0));
        offer_word(make_word(64, 64, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0));
        offer_word(make_word(64, 64, LO, 0, 0, 0, 256, 0, 0, 0, 256, 0));
        offer_word(make_word(-1, 64, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0));
        offer_word(make_word(300, 0, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0));
        // same triangle with b and c swapped
        offer_word(make_word(64, 64, 0, 0, 0, 0, 0, 256, 0, 256, 0, 0));
        // two corners equal, then three collinear corners
        offer_word(make_word(50, 60, 70, 100, 200, 300, 100, 200, 300, 5, 6, 7));
        offer_word(make_word(500, -1000, 1500, 0, 0, 0, 1000, -2000, 3000,
                             2000, -4000, 6000));
        // opposite extremes on every axis
        offer_word(make_word(LO, HI, 0, HI, HI, HI, LO, LO, LO, HI, LO, HI));
        // alternating bit patterns
        offer_word(make_word(0, -1, 1, 21845, -21846, 21845, -21846, 21845, -21846,
                             21845, 21845, -21846));
        wait_for_drain();

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i == 200)
            begin
                // keep offering back to back while the receiver holds off
                hold_off_req = 1'b1;
                steady_left  = 40;
                in_valid <= 1'b0;
                @(posedge clk);
                while (!hold_active)
                    @(posedge clk);
            end
            if (i % 500 == 499)
                wait_for_drain();
            offer_word(random_word());
        end

        wait_for_drain();
        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb_point_in_triangle_test passed");
        else
            $display("tb_point_in_triangle_test failed");
        $finish;
    end

    // receiver: segments of always-ready, random and patterned stalls
    initial
    begin
        int mode;
        int len;
        out_ready = 1'b0;
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                hold_active  = 1'b1;
                repeat (HOLD_CYCLES)
                begin
                    @(posedge clk);
                    out_ready <= 1'b0;
                end
                hold_active = 1'b0;
            end
            else
            begin
                mode = $urandom_range(0, 3);
                len  = $urandom_range(1, 40);
                for (int j = 0; j < len; j++)
                begin
                    @(posedge clk);
                    case (mode)
                        0:       out_ready <= 1'b1;
                        1:       out_ready <= ($urandom_range(0, 1) == 1);
                        2:       out_ready <= ($urandom_range(0, 3) == 0);
                        default: out_ready <= ((j % 3) != 2);
                    endcase
                end
            end
        end
    end

    // watchdog: give up after a long run of cycles with no word moving
    initial
    begin
        int idle;
        idle = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle = 0;
            else
                idle++;
            if (idle >= WATCHDOG_LIMIT)
            begin
                $display("tb_point_in_triangle_test failed");
                $finish;
            end
        end
    end

endmodule

[sim.f]
+incdir+rtl
rtl/pit_pkg.sv
rtl/pit_wide_mul.sv
rtl/point_in_triangle_test.sv
tb/pit_checker.sv
tb/tb_point_in_triangle_test.sv
